// File: rtl/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

	// Default channel width of one RGB component.
	localparam int unsigned CHANNEL_BITS_DEF = 8;

	// Hue and saturation are both 16-bit unsigned fractions.
	localparam int unsigned QUOT_BITS = 16;

endpackage

`default_nettype wire

// File: rtl/rgb_to_hsv_pixel_converter.sv
`default_nettype none

// RGB to HSV pixel converter. Takes one pixel per beat on the pix channel
// (red, green, blue, CHANNEL_BITS each, all-ones = 1.0) and returns one beat
// on the hsv channel: hue as an unsigned Q0.16 fraction of a full turn,
// saturation as floor(65535 * (max - min) / max), brightness equal to the
// largest channel. A grey pixel gets hue 0, a black pixel saturation 0.
// Throughput is one pixel per clock with no gaps while hsv_stall is low.
// One stage picks max/min and the hue sector, one stage forms the two
// dividends and divisors, and the two divisions then run side by side
// through 16 radix-2 restoring stages, one quotient bit per stage. Every
// stage holds a valid bit and loads whenever it is empty or its successor
// moves, so bubbles collapse and the pix side keeps accepting while a
// finished result waits on hsv_stall, until the pipe is full.
module rgb_to_hsv_pixel_converter
	import rgbhsv_pkg::*;
#(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,

	input  wire                     pix_valid,
	output logic                    pix_stall,
	input  wire  [CHANNEL_BITS-1:0] red,
	input  wire  [CHANNEL_BITS-1:0] green,
	input  wire  [CHANNEL_BITS-1:0] blue,

	output logic                    hsv_valid,
	input  wire                     hsv_stall,
	output logic [QUOT_BITS-1:0]    hue,
	output logic [QUOT_BITS-1:0]    saturation,
	output logic [CHANNEL_BITS-1:0] brightness
);

	localparam int unsigned CB  = CHANNEL_BITS;
	localparam int unsigned QB  = QUOT_BITS;
	// 6*d needs three more bits than a channel.
	localparam int unsigned HDW = CB + 3;

	// ------------------------------------------------------------------
	// Handshake: per-stage load enables, bubble collapsing.
	// ld_d[k] loads divider stage k; index 0 is the dividend setup stage.
	// ------------------------------------------------------------------
	logic          v_s1;
	logic [QB:0]   v_d;
	logic [QB:0]   ld_d;
	logic          ld_s1;

	always_comb begin
		ld_d[QB] = !v_d[QB] || !hsv_stall;
		for (int k = QB - 1; k >= 0; k--) begin
			ld_d[k] = !v_d[k] || ld_d[k+1];
		end
		ld_s1 = !v_s1 || ld_d[0];
	end

	assign pix_stall = !ld_s1;

	// ------------------------------------------------------------------
	// Stage 1: max, min, sector.
	// ------------------------------------------------------------------
	logic [CB-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic          red_max_s1, grn_max_s1;

	logic          red_max_c, grn_max_c;
	logic [CB-1:0] mx_c, mn_c, mn_rg_c;

	always_comb begin
		// red wins ties, then green
		red_max_c = (red >= green) && (red >= blue);
		grn_max_c = !red_max_c && (green >= blue);
		if (red_max_c) begin
			mx_c = red;
		end else if (grn_max_c) begin
			mx_c = green;
		end else begin
			mx_c = blue;
		end
		mn_rg_c = (green < red) ? green : red;
		mn_c    = (blue < mn_rg_c) ? blue : mn_rg_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && pix_valid) begin
			r_s1       <= red;
			g_s1       <= green;
			b_s1       <= blue;
			mx_s1      <= mx_c;
			mn_s1      <= mn_c;
			red_max_s1 <= red_max_c;
			grn_max_s1 <= grn_max_c;
		end
	end

	// ------------------------------------------------------------------
	// Divider pipeline registers. Index 0 is the setup stage (stage 2),
	// index k+1 holds the state after quotient bit k.
	// ------------------------------------------------------------------
	logic [HDW-1:0] hrem_s [QB+1];
	logic [HDW-1:0] hdiv_s [QB+1];
	logic [CB-1:0]  srem_s [QB+1];
	logic [CB-1:0]  sdiv_s [QB+1];
	logic [QB-1:0]  slow_s [QB+1];
	logic [QB-1:0]  hq_s   [QB+1];
	logic [QB-1:0]  sq_s   [QB+1];
	logic [CB-1:0]  br_s   [QB+1];

	// ------------------------------------------------------------------
	// Stage 2: dividends and divisors.
	// Hue numerator is kept below 6d, so modular HDW-bit math is exact.
	// Saturation dividend 65535*d = (d << 16) - d; its top CB bits are
	// already below max, so 16 quotient bits suffice.
	// ------------------------------------------------------------------
	logic [CB-1:0]    d_c;
	logic [HDW-1:0]   d6_c, base_c, term_c, num_c;
	logic [CB+QB-1:0] sdvd_c;

	always_comb begin
		d_c  = mx_s1 - mn_s1;
		d6_c = {1'b0, d_c, 2'b00} + {2'b00, d_c, 1'b0};
		if (red_max_s1) begin
			base_c = (g_s1 >= b_s1) ? '0 : d6_c;
			term_c = HDW'(g_s1) - HDW'(b_s1);
		end else if (grn_max_s1) begin
			base_c = {2'b00, d_c, 1'b0};
			term_c = HDW'(b_s1) - HDW'(r_s1);
		end else begin
			base_c = {1'b0, d_c, 2'b00};
			term_c = HDW'(r_s1) - HDW'(g_s1);
		end
		num_c  = base_c + term_c;
		sdvd_c = {d_c, {QB{1'b0}}} - (CB + QB)'(d_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (ld_d[0]) begin
			v_d[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_d[0] && v_s1) begin
			// grey: numerator is zero, divisor forced to 1 gives hue 0
			hrem_s[0] <= num_c;
			hdiv_s[0] <= (d_c == '0) ? HDW'(1) : d6_c;
			srem_s[0] <= sdvd_c[CB+QB-1:QB];
			sdiv_s[0] <= (mx_s1 == '0) ? CB'(1) : mx_s1;
			slow_s[0] <= sdvd_c[QB-1:0];
			hq_s[0]   <= '0;
			sq_s[0]   <= '0;
			br_s[0]   <= mx_s1;
		end
	end

	// ------------------------------------------------------------------
	// Restoring division, one quotient bit per stage for both quotients.
	// ------------------------------------------------------------------
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [HDW:0]   ht;
		logic [CB:0]    st;
		logic           hge, sge;
		logic [HDW-1:0] hrem_n;
		logic [CB-1:0]  srem_n;

		always_comb begin
			ht     = {hrem_s[k], 1'b0};
			hge    = ht >= {1'b0, hdiv_s[k]};
			hrem_n = hge ? HDW'(ht - {1'b0, hdiv_s[k]}) : ht[HDW-1:0];
			st     = {srem_s[k], slow_s[k][QB-1]};
			sge    = st >= {1'b0, sdiv_s[k]};
			srem_n = sge ? CB'(st - {1'b0, sdiv_s[k]}) : st[CB-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (ld_d[k+1]) begin
				v_d[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ld_d[k+1] && v_d[k]) begin
				hrem_s[k+1] <= hrem_n;
				hdiv_s[k+1] <= hdiv_s[k];
				srem_s[k+1] <= srem_n;
				sdiv_s[k+1] <= sdiv_s[k];
				slow_s[k+1] <= {slow_s[k][QB-2:0], 1'b0};
				hq_s[k+1]   <= {hq_s[k][QB-2:0], hge};
				sq_s[k+1]   <= {sq_s[k][QB-2:0], sge};
				br_s[k+1]   <= br_s[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Result beat straight from the last divider stage.
	// ------------------------------------------------------------------
	assign hsv_valid  = v_d[QB];
	assign hue        = hq_s[QB];
	assign saturation = sq_s[QB];
	assign brightness = br_s[QB];

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// a black pixel carries neither saturation nor hue
	a_black_pixel : assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && (brightness == '0) |-> (saturation == '0) && (hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	// input only held off while stage 1 and the setup stage are both occupied
	a_stall_full : assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> v_s1 && v_d[0])
		else $error("input stalled with room in the pipe");

	// a taken result followed by a bubble leaves the output empty
	a_bubble : assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_stall && !v_d[QB-1] |=> !hsv_valid)
		else $error("result repeated after it was taken");

	// an empty last stage always loads
	a_drain : assert property (@(posedge clk) disable iff (!arst_n)
		!v_d[QB] && v_d[QB-1] |=> hsv_valid)
		else $error("result lost between last two stages");

endmodule

`default_nettype wire

// File: tb/sv/rgb_to_hsv_pixel_converter_test.sv
`default_nettype none

module rgb_to_hsv_pixel_converter_test;
	import rgbhsv_pkg::*;

	localparam int unsigned CH = CHANNEL_BITS_DEF;

	// Long receiver hold-off; the pipe is about 18 deep, so this fills it.
	localparam int unsigned LONG_HOLD = 300;
	// Cycles with no beat on either side before the run is declared hung.
	localparam int unsigned HANG_LIMIT = 4000;
	// Drain time after the last expected beat, a bit over the pipe latency.
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned RANDOM_PIXELS = 1000;
	localparam int unsigned MAX_REPORTS = 10;

	// One expected hsv beat, with the pixel it came from for reporting.
	typedef struct {
		logic [CH-1:0]        red;
		logic [CH-1:0]        green;
		logic [CH-1:0]        blue;
		logic [QUOT_BITS-1:0] hue;
		logic [QUOT_BITS-1:0] saturation;
		logic [CH-1:0]        brightness;
	} hsv_beat_t;

	// Holds the hsv beats still owed by the block, oldest first.
	class hsv_ledger;
		hsv_beat_t   pending_hsv[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Fixed-point HSV of one pixel: hue is floor(65536 * turn fraction),
		// saturation floor(65535 * d / max), brightness the largest channel.
		function hsv_beat_t predict_hsv(logic [CH-1:0] r, logic [CH-1:0] g,
			logic [CH-1:0] b);
			hsv_beat_t      beat;
			longint unsigned rl, gl, bl, mx, mn, d, num;
			rl = r;
			gl = g;
			bl = b;
			mx = rl;
			mn = rl;
			if (gl > mx) mx = gl;
			if (bl > mx) mx = bl;
			if (gl < mn) mn = gl;
			if (bl < mn) mn = bl;
			d = mx - mn;
			if (d == 0) begin
				num = 0;
			end else if (mx == rl) begin
				// red sector; wrap by one turn when blue beats green
				num = (gl >= bl) ? gl - bl : 6 * d - (bl - gl);
			end else if (mx == gl) begin
				num = 2 * d + bl - rl;
			end else begin
				num = 4 * d + rl - gl;
			end
			beat.red        = r;
			beat.green      = g;
			beat.blue       = b;
			beat.hue        = (d == 0) ? '0 : QUOT_BITS'((num * 65536) / (6 * d));
			beat.saturation = (mx == 0) ? '0 : QUOT_BITS'((d * 65535) / mx);
			beat.brightness = CH'(mx);
			return beat;
		endfunction

		function void note_pixel(logic [CH-1:0] r, logic [CH-1:0] g, logic [CH-1:0] b);
			pending_hsv.insert(pending_hsv.size(), predict_hsv(r, g, b));
		endfunction

		function void check_hsv(logic [QUOT_BITS-1:0] h, logic [QUOT_BITS-1:0] s,
			logic [CH-1:0] v);
			hsv_beat_t want;
			if (pending_hsv.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected hsv beat: hue %0d sat %0d val %0d", h, s, v);
				return;
			end
			want = pending_hsv.pop_front();
			if (h !== want.hue || s !== want.saturation || v !== want.brightness) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("hsv mismatch rgb %0d,%0d,%0d: want hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
						want.red, want.green, want.blue, want.hue, want.saturation,
						want.brightness, h, s, v);
			end
		endfunction

		function int unsigned owed();
			return pending_hsv.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// pix channel, driven here
	logic          pix_valid = 1'b0;
	logic          pix_stall;
	logic [CH-1:0] red = '0;
	logic [CH-1:0] green = '0;
	logic [CH-1:0] blue = '0;

	// hsv channel, sunk here
	logic                 hsv_valid;
	logic                 hsv_stall = 1'b0;
	logic [QUOT_BITS-1:0] hue;
	logic [QUOT_BITS-1:0] saturation;
	logic [CH-1:0]        brightness;

	// steady: no gaps on either side; long_hold_req: ask the sink for a long stall
	bit steady = 1'b0;
	bit long_hold_req = 1'b0;
	int unsigned idle_cycles = 0;

	hsv_ledger ledger = new();

	rgb_to_hsv_pixel_converter #(
		.CHANNEL_BITS(CH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Offer one pixel, possibly after a gap, and hold it until accepted.
	// Called right after a rising edge; the stall seen there is the value
	// the block sampled at that edge.
	task automatic send_pixel(input logic [CH-1:0] r, input logic [CH-1:0] g,
		input logic [CH-1:0] b);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			red       <= CH'($urandom);
			green     <= CH'($urandom);
			blue      <= CH'($urandom);
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red       <= r;
		green     <= g;
		blue      <= b;
		do @(posedge clk); while (pix_stall);
		ledger.note_pixel(r, g, b);
	endtask

	// Sender pause until every owed beat has come back.
	task automatic drain_pipe();
		pix_valid <= 1'b0;
		do @(posedge clk); while (ledger.owed() != 0);
	endtask

	// Random pixel with a bias toward greys, ties, small spreads and extremes.
	task automatic random_pixel(output logic [CH-1:0] r, output logic [CH-1:0] g,
		output logic [CH-1:0] b);
		int unsigned kind;
		logic [CH-1:0] base;
		kind = $urandom_range(0, 11);
		r = CH'($urandom);
		g = CH'($urandom);
		b = CH'($urandom);
		base = CH'($urandom_range(0, 250));
		case (kind)
			0: begin
				g = r;
				b = r;
			end
			1: g = r;
			2: b = r;
			3: b = g;
			4: begin
				r = base + CH'($urandom_range(0, 4));
				g = base + CH'($urandom_range(0, 4));
				b = base + CH'($urandom_range(0, 4));
			end
			5: begin
				r = ($urandom_range(0, 1) != 0) ? '1 : '0;
				g = CH'($urandom_range(0, 1));
				b = ($urandom_range(0, 1) != 0) ? '1 - 1'b1 : '1;
			end
			default: ;
		endcase
	endtask

	// hsv sink: checks accepted beats, stalls at random, and honors the
	// long hold-off request, counting it down here.
	initial begin : hsv_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && hsv_valid && !hsv_stall)
				ledger.check_hsv(hue, saturation, brightness);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end else if (hold_left == 0 && !steady) begin
				hold_left = pick_gap();
			end
			if (hold_left > 0) begin
				hsv_stall <= 1'b1;
				hold_left--;
			end else begin
				hsv_stall <= 1'b0;
			end
		end
	end

	// Hang guard: no beat on either channel for too long.
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (hsv_valid && !hsv_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("rgb_to_hsv_pixel_converter_test failed");
			$finish;
		end
	end

	// Corner pixels as {red, green, blue}.
	logic [3*CH-1:0] corner_pix [0:21] = '{
		24'h000000,  // black
		24'hffffff,  // white, grey
		24'h808080,  // mid grey
		24'h010101,  // darkest grey
		24'hff0000,  // pure red
		24'h00ff00,  // pure green
		24'h0000ff,  // pure blue
		24'hffff00,  // red and green tie: red wins
		24'hff00ff,  // red and blue tie, green below blue: hue wraps
		24'h00ffff,  // green and blue tie: green wins
		24'hff0001,  // red, blue just above green: hue just under a full turn
		24'hff0100,  // red, green just above blue: hue just above zero
		24'h010000,
		24'h000100,
		24'h000001,
		24'hfffefe,  // near white
		24'hfe00ff,  // blue largest, red just below
		24'h00feff,
		24'hc86432,
		24'h32c864,
		24'h6432c8,
		24'h55aaff
	};

	initial begin : pix_source
		logic [CH-1:0] r, g, b;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, then let the pipe empty
		foreach (corner_pix[i])
			send_pixel(corner_pix[i][3*CH-1:2*CH], corner_pix[i][2*CH-1:CH],
				corner_pix[i][CH-1:0]);
		drain_pipe();

		for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
			// sink holds off while pixels keep coming: pipe fills, pix stalls
			if (n == 250) long_hold_req = 1'b1;
			if (n == 500) drain_pipe();
			// a stretch with back-to-back beats on both sides
			steady = (n >= 650 && n < 800);
			random_pixel(r, g, b);
			send_pixel(r, g, b);
		end
		steady = 1'b0;
		pix_valid <= 1'b0;

		while (ledger.owed() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.mismatches == 0)
			$display("rgb_to_hsv_pixel_converter_test passed");
		else
			$display("rgb_to_hsv_pixel_converter_test failed");
		$finish;
	end

endmodule

`default_nettype wire
